### rtl/fcpd_pkg.sv
package fcpd_pkg;

	localparam int COUNT_W = 25;
	localparam int LEVEL_W = 17;
	localparam int INDEX_W = 3;
	localparam int SUM_W   = 26;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;

	localparam logic [INDEX_W-1:0] REG_RED_MIN         = 3'd0;
	localparam logic [INDEX_W-1:0] REG_LUMA_MIN        = 3'd1;
	localparam logic [INDEX_W-1:0] REG_BLUE_CHROMA_MAX = 3'd2;
	localparam logic [INDEX_W-1:0] REG_RED_CHROMA_MIN  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ALERT_LEVEL     = 3'd4;

	localparam logic [7:0]         RST_RED_MIN         = 8'd210;
	localparam logic [7:0]         RST_LUMA_MIN        = 8'd130;
	localparam logic [7:0]         RST_BLUE_CHROMA_MAX = 8'd120;
	localparam logic [7:0]         RST_RED_CHROMA_MIN  = 8'd150;
	localparam logic [LEVEL_W-1:0] RST_ALERT_LEVEL     = 17'd100;

	localparam logic [LEVEL_W-1:0] SHARE_SCALE = 17'd100000;

	// BT.601 in Q16
	localparam logic signed [SUM_W-1:0] KY_R   = 26'sd19595;
	localparam logic signed [SUM_W-1:0] KY_G   = 26'sd38470;
	localparam logic signed [SUM_W-1:0] KY_B   = 26'sd7471;
	localparam logic signed [SUM_W-1:0] KCB_R  = 26'sd11058;
	localparam logic signed [SUM_W-1:0] KCB_G  = 26'sd21710;
	localparam logic signed [SUM_W-1:0] KCR_G  = 26'sd27439;
	localparam logic signed [SUM_W-1:0] KCR_B  = 26'sd5329;
	localparam logic signed [SUM_W-1:0] K_HALF = 26'sd32768;
	localparam logic signed [SUM_W-1:0] K_OFS  = 26'sd8388608;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pix_in_t;

	typedef struct packed {
		logic               rgb_hit;
		logic               ycbcr_hit;
		logic               fire_pixel;
		logic               frame_done;
		logic               fire_alarm;
		logic [COUNT_W-1:0] fire_count;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] red_min;
		logic [7:0] luma_min;
		logic [7:0] blue_chroma_max;
		logic [7:0] red_chroma_min;
	} thr_t;

	typedef struct packed {
		logic rgb_hit;
		logic ycbcr_hit;
		logic frame_end;
	} class_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [7:0] q16_to_byte(input logic signed [SUM_W-1:0] acc);
		logic signed [SUM_W-1:0] sh;
		sh = acc >>> 16;
		if (acc < 0)
			return 8'd0;
		else if (sh > 255)
			return 8'd255;
		else
			return sh[7:0];
	endfunction

endpackage

### rtl/fcpd_front.sv
module fcpd_front import fcpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pix_valid,
	output logic    pix_stall,
	input  pix_in_t pix,
	input  thr_t    thr,
	input  q_stat_t q_stat,
	output logic    push,
	output class_t  push_data
);

	logic                    v_s1, v_s2;
	logic                    rgb_s1, end_s1;
	logic signed [SUM_W-1:0] y_s1, cb_s1, cr_s1;
	class_t                  cls_s2;
	logic                    rdy_s1, rdy_s2;
	logic signed [SUM_W-1:0] r_x, g_x, b_x;
	logic [7:0]              y_b, cb_b, cr_b;

	assign rdy_s2    = !v_s2 || !q_stat.full;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign pix_stall = !rdy_s1;
	assign push      = v_s2 && !q_stat.full;
	assign push_data = cls_s2;

	assign r_x = $signed({{(SUM_W-8){1'b0}}, pix.red});
	assign g_x = $signed({{(SUM_W-8){1'b0}}, pix.green});
	assign b_x = $signed({{(SUM_W-8){1'b0}}, pix.blue});

	assign y_b  = q16_to_byte(y_s1);
	assign cb_b = q16_to_byte(cb_s1);
	assign cr_b = q16_to_byte(cr_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= pix_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && rdy_s1) begin
			rgb_s1 <= (pix.red > thr.red_min) && (pix.red > pix.green)
				&& (pix.green > pix.blue);
			end_s1 <= pix.frame_end;
			y_s1   <= KY_R * r_x + KY_G * g_x + KY_B * b_x;
			cb_s1  <= K_OFS - KCB_R * r_x - KCB_G * g_x + K_HALF * b_x;
			cr_s1  <= K_OFS + K_HALF * r_x - KCR_G * g_x - KCR_B * b_x;
		end
		if (v_s1 && rdy_s2) begin
			cls_s2.rgb_hit   <= rgb_s1;
			cls_s2.ycbcr_hit <= (y_b > thr.luma_min) && (cb_b < thr.blue_chroma_max)
				&& (cr_b > thr.red_chroma_min);
			cls_s2.frame_end <= end_s1;
		end
	end

endmodule

### rtl/fcpd_queue.sv
module fcpd_queue import fcpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  class_t  push_data,
	input  logic    pop,
	output class_t  pop_data,
	output q_stat_t q_stat
);

	class_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

### rtl/fcpd_back.sv
module fcpd_back import fcpd_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = 16777216
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            q_stat,
	input  class_t             pop_data,
	output logic               pop,
	input  logic [LEVEL_W-1:0] alert_level,
	output logic               res_valid,
	input  logic               res_stall,
	output pix_out_t           res
);

	localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int PW = CW + LEVEL_W;
	localparam logic [CW-1:0] CMAX = CW'(MAX_FRAME_PIXELS);

	logic [CW-1:0] pix_q, fire_q, pix_n, fire_n;
	logic          fire;

	logic          v_s1, v_s2, out_v_q;
	class_t        cls_s1, cls_s2;
	logic [CW-1:0] pix_s1, fire_s1, fire_s2;
	logic [PW-1:0] lhs_s2, rhs_s2;
	logic          rdy_s1, rdy_s2, ld_out;
	logic [CW+COUNT_W-1:0] fire_ext;
	pix_out_t      res_q;

	assign ld_out = v_s2 && (!out_v_q || !res_stall);
	assign rdy_s2 = !v_s2 || ld_out;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign pop    = !q_stat.empty && rdy_s1;

	assign fire   = pop_data.rgb_hit && pop_data.ycbcr_hit;
	assign pix_n  = (pix_q >= CMAX) ? CMAX : pix_q + CW'(1);
	assign fire_n = !fire ? fire_q : ((fire_q >= CMAX) ? CMAX : fire_q + CW'(1));

	assign fire_ext  = {{COUNT_W{1'b0}}, fire_s2};
	assign res_valid = out_v_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q   <= '0;
			fire_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				pix_q  <= pop_data.frame_end ? '0 : pix_n;
				fire_q <= pop_data.frame_end ? '0 : fire_n;
			end
			if (rdy_s1)
				v_s1 <= pop;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (ld_out)
				out_v_q <= 1'b1;
			else if (!res_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_s1  <= pop_data;
			pix_s1  <= pix_n;
			fire_s1 <= fire_n;
		end
		if (v_s1 && rdy_s2) begin
			cls_s2  <= cls_s1;
			fire_s2 <= fire_s1;
			lhs_s2  <= PW'(fire_s1) * PW'(SHARE_SCALE);
			rhs_s2  <= PW'(alert_level) * PW'(pix_s1);
		end
		if (ld_out) begin
			res_q.rgb_hit    <= cls_s2.rgb_hit;
			res_q.ycbcr_hit  <= cls_s2.ycbcr_hit;
			res_q.fire_pixel <= cls_s2.rgb_hit && cls_s2.ycbcr_hit;
			res_q.frame_done <= cls_s2.frame_end;
			res_q.fire_alarm <= cls_s2.frame_end && (lhs_s2 > rhs_s2);
			res_q.fire_count <= fire_ext[COUNT_W-1:0];
		end
	end

endmodule

### rtl/fire_color_pixel_detector.sv
// Fire color pixel detector. Takes one RGB pixel per cycle and returns one result per pixel,
// in order: the RGB rule hit, the YCbCr (BT.601, Q16) rule hit, their AND as the mask bit,
// and the running fire pixel count of the frame. On the pixel marked frame_end the result
// also carries the alarm (fire share above alert_level thousandths of a percent) and both
// frame counters restart. Sustained rate is one item per clock while res_stall stays low.
// The front pipeline (constant multiplies, then the rule compares) feeds a four-item queue;
// the back pipeline updates the counters, then forms the two alarm products, then registers
// the result. Output stall backs up into the queue first, so the input keeps flowing until
// the queue is full. Thresholds must be written through the config port only while no
// pixel is in flight; the block itself does not enforce this. The port is always ready,
// and writes to unknown indexes are dropped.
module fire_color_pixel_detector import fcpd_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = 16777216
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  pix_in_t            pix,
	output logic               res_valid,
	input  logic               res_stall,
	output pix_out_t           res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0] cfg_data
);

	thr_t               thr_q;
	logic [LEVEL_W-1:0] alert_q;
	q_stat_t            q_stat;
	logic               push, pop;
	class_t             push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.red_min         <= RST_RED_MIN;
			thr_q.luma_min        <= RST_LUMA_MIN;
			thr_q.blue_chroma_max <= RST_BLUE_CHROMA_MAX;
			thr_q.red_chroma_min  <= RST_RED_CHROMA_MIN;
			alert_q               <= RST_ALERT_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RED_MIN:         thr_q.red_min         <= cfg_data[7:0];
				REG_LUMA_MIN:        thr_q.luma_min        <= cfg_data[7:0];
				REG_BLUE_CHROMA_MAX: thr_q.blue_chroma_max <= cfg_data[7:0];
				REG_RED_CHROMA_MIN:  thr_q.red_chroma_min  <= cfg_data[7:0];
				REG_ALERT_LEVEL:     alert_q               <= cfg_data;
				default: ;
			endcase
		end
	end

	fcpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.thr       (thr_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	fcpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	fcpd_back #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_data    (pop_data),
		.pop         (pop),
		.alert_level (alert_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule

### rtl/fcpd_checker.sv
module fcpd_checker import fcpd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     res_valid,
	input logic     res_stall,
	input pix_out_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result dropped or changed under stall");

	a_alarm_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.frame_done |-> !res.fire_alarm)
		else $error("alarm outside frame end");

	a_mask_and: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.fire_pixel == (res.rgb_hit && res.ycbcr_hit))
		else $error("mask bit is not the AND of both rules");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fire_pixel |-> res.fire_count != '0)
		else $error("fire pixel with zero count");

endmodule

bind fire_color_pixel_detector fcpd_checker u_fcpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
